>>> src/wts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Windowed trend slope package
// Shared types, field widths and small helper functions for the per-pair
// sliding-window least-squares slope block.
// ----------------------------------------------------------------------------
package wts_pkg;

   localparam int NODE_W      = 3;
   localparam int SAMPLE_W    = 16;
   localparam int SLOPE_W     = 25;
   localparam int HELD_W      = 6;
   localparam int HIST_W      = 6;
   localparam int HIST_RESET  = 10;
   localparam int FRAC_BITS   = 8;
   localparam int MIN_SAMPLES = 2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_META,
      ST_TRIM,
      ST_WALK,
      ST_DRAIN1,
      ST_DRAIN2,
      ST_PROD_A,
      ST_PROD_B,
      ST_PROD_C,
      ST_PROD_D,
      ST_PROD_E,
      ST_DIV_GO,
      ST_DIV_WAIT
   } state_type;

   typedef enum logic [2:0] {
      MUL_IY,
      MUL_N_SXY,
      MUL_SX_SY,
      MUL_N_SXX,
      MUL_SX_SX
   } mul_sel_type;

   typedef struct packed {
      logic        clear;
      logic        issue;
      mul_sel_type mul_sel;
      logic        cap_t;
      logic        cap_num;
      logic        cap_den;
   } dp_cmd_type;

   // Triangular base of a sorted pair: hi*(hi+1)/2.
   function automatic logic [5:0] pair_base(input logic [NODE_W-1:0] hi);
      logic [7:0] prod;
      prod = {1'b0, hi} * ({1'b0, hi} + 4'd1);
      return prod[6:1];
   endfunction

endpackage
`default_nettype wire

>>> src/wts_sample_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sample memory
// One circular buffer of window entries per node pair, one write port and
// one registered read port.
// ----------------------------------------------------------------------------
module wts_sample_ram #(
   parameter int PAIRS      = 36,
   parameter int WINDOW_MAX = 32
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(PAIRS)-1:0]         wr_pair,
   input  logic [$clog2(WINDOW_MAX)-1:0]    wr_pos,
   input  logic [wts_pkg::SAMPLE_W-1:0]     wr_data,
   input  logic [$clog2(PAIRS)-1:0]         rd_pair,
   input  logic [$clog2(WINDOW_MAX)-1:0]    rd_pos,
   output logic [wts_pkg::SAMPLE_W-1:0]     rd_data
);

   logic [wts_pkg::SAMPLE_W-1:0] mem [PAIRS][WINDOW_MAX];
   logic [wts_pkg::SAMPLE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_pair][wr_pos] <= wr_data;
      end
      rd_data_ff <= mem[rd_pair][rd_pos];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> src/wts_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sum and product datapath
// Accumulates the window sums as samples stream out of memory, then forms
// numerator and denominator through one shared, registered multiplier.
// ----------------------------------------------------------------------------
module wts_datapath #(
   parameter int WINDOW_MAX = 32
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  wts_pkg::dp_cmd_type                       cmd,
   input  logic [$clog2(WINDOW_MAX)-1:0]             walk_index,
   input  logic [$clog2(WINDOW_MAX+1)-1:0]           count,
   input  logic [wts_pkg::SAMPLE_W-1:0]              rd_data,
   output logic signed [wts_pkg::SAMPLE_W+4*$clog2(WINDOW_MAX+1):0] num,
   output logic [wts_pkg::SAMPLE_W+4*$clog2(WINDOW_MAX+1)-1:0]      den
);

   localparam int CW     = $clog2(WINDOW_MAX + 1);
   localparam int IW     = $clog2(WINDOW_MAX);
   localparam int AW     = wts_pkg::SAMPLE_W + 2 * CW;
   localparam int BW     = 2 * CW;
   localparam int PROD_W = AW + BW;
   localparam int SYW    = wts_pkg::SAMPLE_W + CW;
   localparam int SXXW   = 3 * CW;

   logic                     rd_v_ff;
   logic                     prod_v_ff;
   logic [IW-1:0]            idx_ff;
   logic [AW-1:0]            op_a;
   logic [BW-1:0]            op_b;
   logic [PROD_W-1:0]        prod;
   logic [PROD_W-1:0]        prod_ff;
   logic [BW-1:0]            sx_ff;
   logic [BW-1:0]            sq_ff;
   logic [SXXW-1:0]          sxx_ff;
   logic [SYW-1:0]           sy_ff;
   logic [AW-1:0]            sxy_ff;
   logic [PROD_W-1:0]        t_ff;
   logic signed [PROD_W:0]   num_ff;
   logic [PROD_W-1:0]        den_ff;

   always_comb begin
      op_a = '0;
      op_b = '0;
      unique case (cmd.mul_sel)
         wts_pkg::MUL_IY: begin
            op_a = AW'(rd_data);
            op_b = BW'(idx_ff);
         end
         wts_pkg::MUL_N_SXY: begin
            op_a = sxy_ff;
            op_b = BW'(count);
         end
         wts_pkg::MUL_SX_SY: begin
            op_a = AW'(sy_ff);
            op_b = sx_ff;
         end
         wts_pkg::MUL_N_SXX: begin
            op_a = AW'(sxx_ff);
            op_b = BW'(count);
         end
         wts_pkg::MUL_SX_SX: begin
            op_a = AW'(sx_ff);
            op_b = sx_ff;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   assign prod = op_a * op_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff   <= 1'b0;
         prod_v_ff <= 1'b0;
      end else begin
         rd_v_ff   <= cmd.issue;
         prod_v_ff <= rd_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= walk_index;
      prod_ff <= prod;
      if (cmd.clear) begin
         sx_ff  <= '0;
         sq_ff  <= '0;
         sxx_ff <= '0;
         sy_ff  <= '0;
         sxy_ff <= '0;
      end else begin
         // The square of the index is kept incrementally: (j+1)^2 = j^2 + 2j + 1.
         if (rd_v_ff) begin
            sx_ff  <= sx_ff + BW'(idx_ff);
            sq_ff  <= sq_ff + BW'({idx_ff, 1'b1});
            sxx_ff <= sxx_ff + SXXW'(sq_ff);
            sy_ff  <= sy_ff + SYW'(rd_data);
         end
         if (prod_v_ff) begin
            sxy_ff <= sxy_ff + AW'(prod_ff);
         end
      end
      if (cmd.cap_t) begin
         t_ff <= prod_ff;
      end
      if (cmd.cap_num) begin
         num_ff <= $signed({1'b0, t_ff}) - $signed({1'b0, prod_ff});
      end
      if (cmd.cap_den) begin
         den_ff <= t_ff - prod_ff;
      end
   end

   assign num = num_ff;
   assign den = den_ff;

endmodule
`default_nettype wire

>>> src/wts_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Slope divider
// Restoring divider, one quotient bit per cycle, giving the scaled quotient
// truncated toward zero and saturated to the slope range.
// ----------------------------------------------------------------------------
module wts_divider #(
   parameter int PROD_W = 40
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [PROD_W:0]              num,
   input  logic [PROD_W-1:0]                   den,
   output logic                                done,
   output logic signed [wts_pkg::SLOPE_W-1:0]  slope
);

   localparam int QW     = wts_pkg::SLOPE_W;
   localparam int DW     = PROD_W + wts_pkg::FRAC_BITS;
   localparam int STEP_W = $clog2(QW);
   localparam logic [QW-1:0] POS_MAX = {1'b0, {(QW-1){1'b1}}};
   localparam logic [QW-1:0] NEG_MIN = {1'b1, {(QW-1){1'b0}}};

   logic [PROD_W:0]   neg_num;
   logic [PROD_W-1:0] mag;
   logic [DW-1:0]     dividend;
   logic [DW-QW-1:0]  dvd_hi;
   logic              over;
   logic [PROD_W:0]   trial;
   logic              fits;

   logic              run_ff;
   logic              done_ff;
   logic [STEP_W-1:0] step_ff;
   logic [PROD_W-1:0] rem_ff;
   logic [QW-1:0]     low_ff;
   logic [QW-1:0]     q_ff;
   logic              neg_ff;
   logic              over_ff;
   logic [QW-1:0]     slope_bits;

   assign neg_num  = -num;
   assign mag      = num[PROD_W] ? neg_num[PROD_W-1:0] : num[PROD_W-1:0];
   assign dividend = {mag, {wts_pkg::FRAC_BITS{1'b0}}};
   assign dvd_hi   = dividend[DW-1:QW];
   // The quotient needs more bits than the slope holds exactly when the
   // dividend's upper part already reaches the divisor.
   assign over     = PROD_W'(dvd_hi) >= den;
   assign trial    = {rem_ff, low_ff[QW-1]};
   assign fits     = trial >= {1'b0, den};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff  <= 1'b1;
            step_ff <= '0;
         end else if (run_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_W'(QW - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= PROD_W'(dvd_hi);
         low_ff  <= dividend[QW-1:0];
         q_ff    <= '0;
         neg_ff  <= num[PROD_W];
         over_ff <= over;
      end else if (run_ff) begin
         rem_ff <= fits ? PROD_W'(trial - {1'b0, den}) : PROD_W'(trial);
         low_ff <= {low_ff[QW-2:0], 1'b0};
         q_ff   <= {q_ff[QW-2:0], fits};
      end
   end

   always_comb begin
      if (neg_ff) begin
         slope_bits = (over_ff || (q_ff > NEG_MIN)) ? NEG_MIN : (~q_ff + 1'b1);
      end else begin
         slope_bits = (over_ff || q_ff[QW-1]) ? POS_MAX : q_ff;
      end
   end

   assign done  = done_ff;
   assign slope = $signed(slope_bits);

endmodule
`default_nettype wire

>>> src/windowed_trend_slope.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Windowed trend slope
// Per node-pair sliding window of samples with a least-squares slope of the
// window against sample position, computed on one shared multiplier and a
// bit-serial divider.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; the block then stays
// busy until the cycle in which its single result is strobed on rsp_strobe for
// one cycle, and the receiver has no way to hold that result back. A request
// whose pair holds fewer than two samples after the update is answered from the
// trim step; otherwise the block walks the n samples held, up to a full window
// of 32, through the single read port of the sample memory, forms the products
// on the shared multiplier and runs the one-bit-per-cycle divider. There is no
// clearing pass after reset: the per-pair counts carry valid bits that reset
// clears at once. The history length register may only be written while busy
// is low.
// ----------------------------------------------------------------------------
module windowed_trend_slope #(
   parameter int NODES      = 8,
   parameter int WINDOW_MAX = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [wts_pkg::NODE_W-1:0]          req_first_node,
   input  logic [wts_pkg::NODE_W-1:0]          req_second_node,
   input  logic [wts_pkg::SAMPLE_W-1:0]        req_sample,
   output logic                                rsp_strobe,
   output logic signed [wts_pkg::SLOPE_W-1:0]  rsp_slope,
   output logic                                rsp_enough_history,
   output logic [wts_pkg::HELD_W-1:0]          rsp_samples_held,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [wts_pkg::HIST_W-1:0]          csr_history_length
);

   localparam int NODE_W  = wts_pkg::NODE_W;
   localparam int HELD_W  = wts_pkg::HELD_W;
   localparam int HIST_W  = wts_pkg::HIST_W;
   localparam int SLOPE_W = wts_pkg::SLOPE_W;
   localparam int PAIRS   = NODES * (NODES + 1) / 2;
   localparam int PW      = $clog2(PAIRS);
   localparam int CW      = $clog2(WINDOW_MAX + 1);
   localparam int IW      = $clog2(WINDOW_MAX);
   localparam int PROD_W  = wts_pkg::SAMPLE_W + 4 * CW;

   // Count and oldest position of one pair's window.
   typedef struct packed {
      logic [CW-1:0] count;
      logic [IW-1:0] oldest;
   } meta_type;

   function automatic logic [NODE_W-1:0] clamp_node(input logic [NODE_W-1:0] v);
      return (32'(v) >= NODES) ? NODE_W'(NODES - 1) : v;
   endfunction

   // Positions stay below twice the window size, so one subtract wraps them.
   function automatic logic [IW-1:0] wrap_pos(input logic [IW:0] v);
      return (v >= (IW + 1)'(WINDOW_MAX)) ? IW'(v - (IW + 1)'(WINDOW_MAX)) : IW'(v);
   endfunction

   // ---------------------------------------------------------------------
   // Request decode: sort the pair and number it.
   // ---------------------------------------------------------------------
   logic [NODE_W-1:0] node_a;
   logic [NODE_W-1:0] node_b;
   logic [NODE_W-1:0] node_lo;
   logic [NODE_W-1:0] node_hi;
   logic [5:0]        pair_sum;
   logic [PW-1:0]     pair_in;
   logic              accept;

   assign node_a   = clamp_node(req_first_node);
   assign node_b   = clamp_node(req_second_node);
   assign node_lo  = (node_a < node_b) ? node_a : node_b;
   assign node_hi  = (node_a < node_b) ? node_b : node_a;
   assign pair_sum = wts_pkg::pair_base(node_hi) + 6'(node_lo);
   assign pair_in  = PW'(pair_sum);
   assign accept   = start && !busy;

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   wts_pkg::state_type          state_ff, state_in;
   logic [HIST_W-1:0]           hist_ff;
   logic [PW-1:0]               pair_ff;
   logic [wts_pkg::SAMPLE_W-1:0] sample_ff;
   logic [CW-1:0]               cnt_ff, cnt_in;
   logic [IW-1:0]               old_ff, old_in;
   logic [IW-1:0]               idx_ff, idx_in;
   logic                        rsp_strobe_ff, rsp_strobe_in;
   logic signed [SLOPE_W-1:0]   rsp_slope_ff, rsp_slope_in;
   logic                        rsp_enough_ff, rsp_enough_in;
   logic [HELD_W-1:0]           rsp_held_ff, rsp_held_in;

   // Pair metadata memory with one valid bit per pair; a pair that was never
   // written reads as an empty window.
   meta_type                    meta_mem [PAIRS];
   meta_type                    meta_rd_ff;
   meta_type                    meta_wr;
   logic                        meta_we;
   logic [PAIRS-1:0]            valid_ff;
   logic                        meta_hit_ff;

   // ---------------------------------------------------------------------
   // Window update arithmetic
   // ---------------------------------------------------------------------
   logic [CW-1:0] limit;
   logic [CW-1:0] cnt_raw;
   logic [IW-1:0] old_raw;
   logic          full;
   logic [CW-1:0] cnt_app;
   logic [IW-1:0] old_app;
   logic [IW-1:0] wr_pos;
   logic          excess;
   logic [CW-1:0] cnt_trim;
   logic [IW-1:0] old_trim;
   logic [IW-1:0] old_drop;
   logic [IW-1:0] rd_pos;
   logic          walk_last;

   assign limit   = (32'(hist_ff) > WINDOW_MAX) ? CW'(WINDOW_MAX) : CW'(hist_ff);
   assign cnt_raw = meta_hit_ff ? meta_rd_ff.count : '0;
   assign old_raw = meta_hit_ff ? meta_rd_ff.oldest : '0;

   // A full buffer loses its oldest sample before the append.
   assign full    = (cnt_raw == CW'(WINDOW_MAX));
   assign old_app = full ? wrap_pos({1'b0, old_raw} + 1'b1) : old_raw;
   assign cnt_app = full ? CW'(WINDOW_MAX - 1) : cnt_raw;
   assign wr_pos  = wrap_pos({1'b0, old_app} + (IW + 1)'(cnt_app));

   // After the append, everything above the history length is dropped at
   // once; an emptied window restarts at position zero.
   assign excess   = (cnt_ff > limit);
   assign old_drop = wrap_pos({1'b0, old_ff} + (IW + 1)'(cnt_ff - limit));
   assign cnt_trim = excess ? limit : cnt_ff;
   assign old_trim = (cnt_trim == '0) ? '0 : (excess ? old_drop : old_ff);

   assign rd_pos    = wrap_pos({1'b0, old_ff} + (IW + 1)'(idx_ff));
   assign walk_last = (idx_ff == IW'(cnt_ff - CW'(1)));

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   wts_pkg::dp_cmd_type         cmd;
   logic                        ram_we;
   logic                        div_start;
   logic                        div_done;
   logic signed [SLOPE_W-1:0]   div_slope;
   logic [wts_pkg::SAMPLE_W-1:0] ram_rd_data;
   logic signed [PROD_W:0]      dp_num;
   logic [PROD_W-1:0]           dp_den;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wts_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd.clear     = 1'b0;
      cmd.issue     = 1'b0;
      cmd.mul_sel   = wts_pkg::MUL_IY;
      cmd.cap_t     = 1'b0;
      cmd.cap_num   = 1'b0;
      cmd.cap_den   = 1'b0;
      ram_we        = 1'b0;
      meta_we       = 1'b0;
      meta_wr.count  = cnt_trim;
      meta_wr.oldest = old_trim;
      div_start     = 1'b0;
      cnt_in        = cnt_ff;
      old_in        = old_ff;
      idx_in        = idx_ff;
      rsp_strobe_in = 1'b0;
      rsp_slope_in  = '0;
      rsp_enough_in = 1'b0;
      rsp_held_in   = HELD_W'(cnt_trim);
      unique case (state_ff)
         wts_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = wts_pkg::ST_META;
            end
         end
         wts_pkg::ST_META: begin
            ram_we   = 1'b1;
            cnt_in   = CW'(cnt_app + 1'b1);
            old_in   = old_app;
            state_in = wts_pkg::ST_TRIM;
         end
         wts_pkg::ST_TRIM: begin
            meta_we = 1'b1;
            cnt_in  = cnt_trim;
            old_in  = old_trim;
            if (cnt_trim < CW'(wts_pkg::MIN_SAMPLES)) begin
               rsp_strobe_in = 1'b1;
               rsp_held_in   = HELD_W'(cnt_trim);
               state_in      = wts_pkg::ST_IDLE;
            end else begin
               cmd.clear = 1'b1;
               idx_in    = '0;
               state_in  = wts_pkg::ST_WALK;
            end
         end
         wts_pkg::ST_WALK: begin
            cmd.issue = 1'b1;
            idx_in    = idx_ff + 1'b1;
            if (walk_last) begin
               state_in = wts_pkg::ST_DRAIN1;
            end
         end
         wts_pkg::ST_DRAIN1: begin
            state_in = wts_pkg::ST_DRAIN2;
         end
         wts_pkg::ST_DRAIN2: begin
            state_in = wts_pkg::ST_PROD_A;
         end
         wts_pkg::ST_PROD_A: begin
            cmd.mul_sel = wts_pkg::MUL_N_SXY;
            state_in    = wts_pkg::ST_PROD_B;
         end
         wts_pkg::ST_PROD_B: begin
            cmd.mul_sel = wts_pkg::MUL_SX_SY;
            cmd.cap_t   = 1'b1;
            state_in    = wts_pkg::ST_PROD_C;
         end
         wts_pkg::ST_PROD_C: begin
            cmd.mul_sel = wts_pkg::MUL_N_SXX;
            cmd.cap_num = 1'b1;
            state_in    = wts_pkg::ST_PROD_D;
         end
         wts_pkg::ST_PROD_D: begin
            cmd.mul_sel = wts_pkg::MUL_SX_SX;
            cmd.cap_t   = 1'b1;
            state_in    = wts_pkg::ST_PROD_E;
         end
         wts_pkg::ST_PROD_E: begin
            cmd.cap_den = 1'b1;
            state_in    = wts_pkg::ST_DIV_GO;
         end
         wts_pkg::ST_DIV_GO: begin
            div_start = 1'b1;
            state_in  = wts_pkg::ST_DIV_WAIT;
         end
         wts_pkg::ST_DIV_WAIT: begin
            if (div_done) begin
               rsp_strobe_in = 1'b1;
               rsp_slope_in  = div_slope;
               rsp_enough_in = 1'b1;
               rsp_held_in   = HELD_W'(cnt_ff);
               state_in      = wts_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wts_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pair_ff   <= pair_in;
         sample_ff <= req_sample;
      end
      cnt_ff <= cnt_in;
      old_ff <= old_in;
      idx_ff <= idx_in;
   end

   // Metadata memory: written once per request, read at the incoming pair.
   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[pair_ff] <= meta_wr;
      end
      meta_rd_ff  <= meta_mem[pair_in];
      meta_hit_ff <= valid_ff[pair_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (meta_we) begin
         valid_ff[pair_ff] <= 1'b1;
      end
   end

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff <= HIST_W'(wts_pkg::HIST_RESET);
      end else if (csr_valid && csr_ready) begin
         hist_ff <= csr_history_length;
      end
   end

   // Result register: shown for exactly one cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_strobe_in) begin
         rsp_slope_ff  <= rsp_slope_in;
         rsp_enough_ff <= rsp_enough_in;
         rsp_held_ff   <= rsp_held_in;
      end
   end

   // ---------------------------------------------------------------------
   // Units
   // ---------------------------------------------------------------------
   wts_sample_ram #(
      .PAIRS      (PAIRS),
      .WINDOW_MAX (WINDOW_MAX)
   ) u_sample_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_pair (pair_ff),
      .wr_pos  (wr_pos),
      .wr_data (sample_ff),
      .rd_pair (pair_ff),
      .rd_pos  (rd_pos),
      .rd_data (ram_rd_data)
   );

   wts_datapath #(
      .WINDOW_MAX (WINDOW_MAX)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .walk_index (idx_ff),
      .count      (cnt_ff),
      .rd_data    (ram_rd_data),
      .num        (dp_num),
      .den        (dp_den)
   );

   wts_divider #(
      .PROD_W (PROD_W)
   ) u_divider (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (dp_num),
      .den   (dp_den),
      .done  (div_done),
      .slope (div_slope)
   );

   assign busy               = (state_ff != wts_pkg::ST_IDLE);
   assign csr_ready          = !busy;
   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_slope          = rsp_slope_ff;
   assign rsp_enough_history = rsp_enough_ff;
   assign rsp_samples_held   = rsp_held_ff;

`ifndef ASSERT_OFF
   a_strobe_ends_work: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result strobed without a request in progress");

   a_short_window_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_enough_history) |-> (rsp_slope == '0))
      else $error("non-zero slope for a window with fewer than two samples");

   a_walk_has_pairs: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wts_pkg::ST_WALK) |-> (cnt_ff >= CW'(wts_pkg::MIN_SAMPLES)))
      else $error("window walk started with fewer than two samples");

   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == wts_pkg::ST_DIV_WAIT))
      else $error("divider finished while the sequencer was not waiting");
`endif

endmodule
`default_nettype wire
